### hdl/kli_pkg.sv
// Shared constants, command and status types for the keyframe interpolator.
// No dependencies; compile first.
package kli_pkg;

  localparam int MAX_KEYS  = 64;
  localparam int KEY_WORDS = 14;
  localparam int NUM_COMP  = 13;
  localparam int DATA_W    = 32;
  localparam int LANE_W    = 4;
  localparam int COMP_W    = 4;
  localparam int FRAC_W    = 16;
  localparam int KEY_W     = $clog2(MAX_KEYS);
  localparam int CNT_W     = $clog2(MAX_KEYS + 1);
  localparam int MEM_DEPTH = MAX_KEYS * KEY_WORDS;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int DIV_CNT_W = $clog2(FRAC_W);

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [LANE_W-1:0] LANE_TIME   = LANE_W'(0);
  localparam logic [LANE_W-1:0] LANE_APPEND = LANE_W'(KEY_WORDS - 1);

  typedef enum logic [1:0] {
    EMIT_ACK  = 2'd0,
    EMIT_NF   = 2'd1,
    EMIT_COMP = 2'd2
  } emit_t;

  typedef struct packed {
    logic              load;
    logic              mem_rd;
    logic [KEY_W-1:0]  rd_key;
    logic [LANE_W-1:0] rd_lane;
    logic              save_q;
    logic              scan_next;
    logic              span_init;
    logic              clr_frac;
    logic              div_step;
    logic              latch_a;
    logic              mul;
    logic              emit;
    emit_t             emit_sel;
    logic [COMP_W-1:0] comp;
    logic              last;
  } kli_cmd_t;

  typedef struct packed {
    logic             out_free;
    logic             count_zero;
    logic             greater;
    logic [CNT_W-1:0] count;
  } kli_stat_t;

endpackage

### hdl/kli_ctrl.sv
// Sequencer for loads and queries: scan, divide, per-component read/multiply/emit.
// Depends on kli_pkg.
module kli_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_kind,
  output logic              in_tready,
  input  kli_pkg::kli_stat_t stat,
  output kli_pkg::kli_cmd_t  cmd
);
  import kli_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_LACK = 10'b0000000010,
    S_NF   = 10'b0000000100,
    S_SRD  = 10'b0000001000,
    S_SCMP = 10'b0000010000,
    S_DIV  = 10'b0000100000,
    S_ARD  = 10'b0001000000,
    S_BRD  = 10'b0010000000,
    S_MUL  = 10'b0100000000,
    S_EMIT = 10'b1000000000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [KEY_W-1:0]       idx_r, idx_nxt;
  logic [KEY_W-1:0]       sk_r, sk_nxt;
  logic [KEY_W-1:0]       ek_r, ek_nxt;
  logic [COMP_W-1:0]      comp_r, comp_nxt;
  logic [DIV_CNT_W-1:0]   dcnt_r, dcnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    idx_r  <= idx_nxt;
    sk_r   <= sk_nxt;
    ek_r   <= ek_nxt;
    comp_r <= comp_nxt;
    dcnt_r <= dcnt_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    sk_nxt    = sk_r;
    ek_nxt    = ek_r;
    comp_nxt  = comp_r;
    dcnt_nxt  = dcnt_r;
    in_tready = 1'b0;
    cmd       = '0;
    cmd.emit_sel = EMIT_ACK;
    cmd.comp  = comp_r;
    cmd.last  = (comp_r == COMP_W'(NUM_COMP - 1));
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_kind == KIND_LOAD) begin
            cmd.load  = 1'b1;
            state_nxt = S_LACK;
          end else begin
            cmd.save_q = 1'b1;
            idx_nxt    = '0;
            state_nxt  = stat.count_zero ? S_NF : S_SRD;
          end
        end
      end
      S_LACK: begin
        if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_ACK;
          state_nxt    = S_IDLE;
        end
      end
      S_NF: begin
        if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_NF;
          state_nxt    = S_IDLE;
        end
      end
      S_SRD: begin
        cmd.mem_rd  = 1'b1;
        cmd.rd_key  = idx_r;
        cmd.rd_lane = LANE_TIME;
        state_nxt   = S_SCMP;
      end
      S_SCMP: begin
        comp_nxt = '0;
        if (stat.greater) begin
          if (idx_r == '0) begin
            // clamp: span of key 0 to itself with zero fraction
            cmd.clr_frac = 1'b1;
            sk_nxt       = '0;
            ek_nxt       = '0;
            state_nxt    = S_ARD;
          end else begin
            cmd.span_init = 1'b1;
            sk_nxt        = idx_r - KEY_W'(1);
            ek_nxt        = idx_r;
            dcnt_nxt      = '0;
            state_nxt     = S_DIV;
          end
        end else begin
          cmd.scan_next = 1'b1;
          if ({1'b0, idx_r} == CNT_W'(stat.count - CNT_W'(1))) begin
            state_nxt = S_NF;
          end else begin
            idx_nxt   = idx_r + KEY_W'(1);
            state_nxt = S_SRD;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        dcnt_nxt     = dcnt_r + DIV_CNT_W'(1);
        if (dcnt_r == DIV_CNT_W'(FRAC_W - 1)) begin
          state_nxt = S_ARD;
        end
      end
      S_ARD: begin
        cmd.mem_rd  = 1'b1;
        cmd.rd_key  = sk_r;
        cmd.rd_lane = LANE_W'(comp_r) + LANE_W'(1);
        state_nxt   = S_BRD;
      end
      S_BRD: begin
        cmd.mem_rd  = 1'b1;
        cmd.rd_key  = ek_r;
        cmd.rd_lane = LANE_W'(comp_r) + LANE_W'(1);
        cmd.latch_a = 1'b1;
        state_nxt   = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_COMP;
          if (comp_r == COMP_W'(NUM_COMP - 1)) begin
            state_nxt = S_IDLE;
          end else begin
            comp_nxt  = comp_r + COMP_W'(1);
            state_nxt = S_ARD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### hdl/kli_dp.sv
// Datapath: key memory, scan compare, restoring divider, multiply-add, result register.
// Depends on kli_pkg.
module kli_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [kli_pkg::LANE_W-1:0]  in_lane,
  input  logic [kli_pkg::DATA_W-1:0]  in_value,
  input  kli_pkg::kli_cmd_t           cmd,
  output kli_pkg::kli_stat_t          stat,
  input  logic                        out_tready,
  output logic                        out_valid,
  output logic                        out_kind,
  output logic [kli_pkg::COMP_W-1:0]  out_comp,
  output logic [kli_pkg::DATA_W-1:0]  out_value,
  output logic                        out_found,
  output logic                        out_acc,
  output logic                        out_last
);
  import kli_pkg::*;

  logic [DATA_W-1:0]        mem [MEM_DEPTH];
  logic [DATA_W-1:0]        rdata_r;
  logic [CNT_W-1:0]         count_r;
  logic                     acc_r;
  logic signed [DATA_W-1:0] qtime_r, prev_r, a_r;
  logic [DATA_W-1:0]        rem_r, dur_r;
  logic [FRAC_W-1:0]        frac_r;
  logic signed [DATA_W+FRAC_W+1:0] prod_r;

  logic                     out_valid_r, out_kind_r, out_found_r, out_acc_r, out_last_r;
  logic [COMP_W-1:0]        out_comp_r;
  logic [DATA_W-1:0]        out_value_r;

  logic                     load_ok;
  logic [ADDR_W-1:0]        wr_addr, rd_addr;
  logic signed [DATA_W:0]   el, dur, diff;
  logic [DATA_W:0]          r2;
  logic [DATA_W-1:0]        interp;

  assign load_ok = (in_lane < LANE_W'(KEY_WORDS)) && (count_r < CNT_W'(MAX_KEYS));
  assign wr_addr = ADDR_W'(count_r[KEY_W-1:0]) * ADDR_W'(KEY_WORDS) + ADDR_W'(in_lane);
  assign rd_addr = ADDR_W'(cmd.rd_key) * ADDR_W'(KEY_WORDS) + ADDR_W'(cmd.rd_lane);
  assign el      = {qtime_r[DATA_W-1], qtime_r} - {prev_r[DATA_W-1], prev_r};
  assign dur     = {rdata_r[DATA_W-1], rdata_r} - {prev_r[DATA_W-1], prev_r};
  assign diff    = {rdata_r[DATA_W-1], rdata_r} - {a_r[DATA_W-1], a_r};
  assign r2      = {rem_r, 1'b0};
  assign interp  = a_r + prod_r[FRAC_W +: DATA_W];

  always_ff @(posedge clk) begin
    if (cmd.load && load_ok) begin
      mem[wr_addr] <= in_value;
    end
    if (cmd.mem_rd) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load && load_ok && in_lane == LANE_APPEND) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc_r <= load_ok;
    end
    if (cmd.save_q) begin
      qtime_r <= in_value;
    end
    if (cmd.scan_next) begin
      prev_r <= rdata_r;
    end
    if (cmd.clr_frac) begin
      frac_r <= '0;
    end
    if (cmd.span_init) begin
      rem_r  <= el[DATA_W-1:0];
      dur_r  <= dur[DATA_W-1:0];
      frac_r <= '0;
    end
    if (cmd.div_step) begin
      // one quotient bit per cycle
      if (r2 >= {1'b0, dur_r}) begin
        rem_r  <= DATA_W'(r2 - {1'b0, dur_r});
        frac_r <= {frac_r[FRAC_W-2:0], 1'b1};
      end else begin
        rem_r  <= r2[DATA_W-1:0];
        frac_r <= {frac_r[FRAC_W-2:0], 1'b0};
      end
    end
    if (cmd.latch_a) begin
      a_r <= rdata_r;
    end
    if (cmd.mul) begin
      prod_r <= diff * $signed({1'b0, frac_r});
    end
    if (cmd.emit) begin
      out_last_r <= 1'b1;
      out_comp_r <= '0;
      out_value_r <= '0;
      out_found_r <= 1'b0;
      out_acc_r  <= 1'b0;
      out_kind_r <= KIND_QUERY;
      case (cmd.emit_sel)
        EMIT_ACK: begin
          out_kind_r <= KIND_LOAD;
          out_acc_r  <= acc_r;
        end
        EMIT_NF: begin
          out_kind_r <= KIND_QUERY;
        end
        EMIT_COMP: begin
          out_comp_r  <= cmd.comp;
          out_value_r <= interp;
          out_found_r <= 1'b1;
          out_last_r  <= cmd.last;
        end
        default: begin
          out_kind_r <= KIND_QUERY;
        end
      endcase
    end
  end

  assign stat.out_free   = !out_valid_r || out_tready;
  assign stat.count_zero = (count_r == '0);
  assign stat.greater    = $signed(rdata_r) > qtime_r;
  assign stat.count      = count_r;

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_comp  = out_comp_r;
  assign out_value = out_value_r;
  assign out_found = out_found_r;
  assign out_acc   = out_acc_r;
  assign out_last  = out_last_r;

endmodule

### hdl/keyframe_linear_interpolator.sv
// Top level of the keyframe interpolator: stream ports, controller and datapath.
// Depends on kli_pkg, kli_ctrl, kli_dp.

// Keyframe table of up to 64 keys (time plus 13 Q16.16 components each) with
// linear interpolation. Load requests (tuser 0) write one word of the key being
// built; lane 13 appends it. Each load gives one acknowledge. A query request
// (tuser 1) scans key times in load order through the single registered memory
// read port, runs a restoring divide for the 16-bit fraction, then for each
// component does two reads, a multiply and an emit. One request is in work at
// a time; new requests are taken once the previous one has placed its last
// result in the output register, which may still be waiting on out_tready.
module keyframe_linear_interpolator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // lane[3:0], value[35:4], zero pad
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // component[3:0], out_value[35:4], found[36],
                                  // accepted[37], zero pad
  output logic        out_tuser,  // result_kind
  output logic        out_tlast   // last
);
  import kli_pkg::*;

  kli_cmd_t          cmd;
  kli_stat_t         stat;
  logic [COMP_W-1:0] o_comp;
  logic [DATA_W-1:0] o_value;
  logic              o_found, o_acc;

  // Hold request fields straight off the bus; only read on the accept cycle.
  kli_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  kli_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_lane    (in_tdata[LANE_W-1:0]),
    .in_value   (in_tdata[LANE_W +: DATA_W]),
    .cmd        (cmd),
    .stat       (stat),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_kind   (out_tuser),
    .out_comp   (o_comp),
    .out_value  (o_value),
    .out_found  (o_found),
    .out_acc    (o_acc),
    .out_last   (out_tlast)
  );

  // Pack result fields, lowest first, pad to whole bytes.
  assign out_tdata = {2'b00, o_acc, o_found, o_value, o_comp};

endmodule

### hdl/kli_checker.sv
// Port-level checks on the keyframe interpolator result stream, and its bind.
// Depends on keyframe_linear_interpolator.
module kli_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  logic take;
  assign take = out_tvalid && out_tready;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_ack_single: assert property (@(posedge clk) disable iff (!rst_n)
    take && !out_tuser |-> out_tlast && out_tdata[35:0] == 36'd0 && !out_tdata[36])
    else $error("load acknowledge malformed");

  a_miss_single: assert property (@(posedge clk) disable iff (!rst_n)
    take && out_tuser && !out_tdata[36] |-> out_tlast && !out_tdata[37])
    else $error("not-found result malformed");

  a_last_comp: assert property (@(posedge clk) disable iff (!rst_n)
    take && out_tuser && out_tdata[36] |-> out_tlast == (out_tdata[3:0] == 4'd12))
    else $error("last flag not on final component");

  a_comp_order: assert property (@(posedge clk) disable iff (!rst_n)
    take && out_tuser && out_tdata[36] && !out_tlast ##1 (out_tvalid && out_tready)
    |-> out_tuser && out_tdata[36] && out_tdata[3:0] == $past(out_tdata[3:0]) + 4'd1)
    else $error("component sequence broken");

endmodule

bind keyframe_linear_interpolator kli_checker u_kli_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

### sim/testbench.sv
// Self-checking bench for keyframe_linear_interpolator: random and directed key loads and
// time queries, checked against a behavioral model of the key table held in a scoreboard.
// Depends on kli_pkg and the keyframe_linear_interpolator RTL.
`timescale 1ns / 100ps

import kli_pkg::*;

typedef struct packed {
  logic        rkind;
  logic [3:0]  comp;
  logic [31:0] val;
  logic        found;
  logic        acc;
  logic        last;
} kf_result_t;

class kf_scoreboard;
  logic [31:0] key_words [MEM_DEPTH];
  int          key_count;
  logic [13:0] slot_mask;   // lanes written so far in the key being built
  kf_result_t  expected_q [$];
  int          errors;

  function new();
    key_count = 0;
    slot_mask = '0;
    errors    = 0;
  endfunction

  function automatic longint word(int k, int ln);
    return longint'($signed(key_words[k * KEY_WORDS + ln]));
  endfunction

  function automatic void push(logic rk, int c, logic [31:0] v, logic f, logic a, logic l);
    kf_result_t r;
    r.rkind = rk; r.comp = c[3:0]; r.val = v; r.found = f; r.acc = a; r.last = l;
    expected_q.push_back(r);
  endfunction

  // Predict the results of one accepted request.
  function automatic void note(logic kind, logic [3:0] lane, logic [31:0] value);
    longint t, t0, dur, el, frac, a, b;
    int i;
    if (kind == KIND_LOAD) begin
      if (lane < KEY_WORDS && key_count < MAX_KEYS) begin
        key_words[key_count * KEY_WORDS + lane] = value;
        slot_mask[lane] = 1'b1;
        if (lane == LANE_APPEND) begin
          key_count++;
          slot_mask = '0;
        end
        push(1'b0, 0, '0, 1'b0, 1'b1, 1'b1);
      end else begin
        push(1'b0, 0, '0, 1'b0, 1'b0, 1'b1);
      end
      return;
    end
    t = longint'($signed(value));
    i = 0;
    while (i < key_count && word(i, 0) <= t) i++;
    if (i >= key_count) begin
      push(1'b1, 0, '0, 1'b0, 1'b0, 1'b1);
    end else if (i == 0) begin
      for (int c = 0; c < NUM_COMP; c++)
        push(1'b1, c, key_words[c + 1], 1'b1, 1'b0, c == NUM_COMP - 1);
    end else begin
      t0   = word(i - 1, 0);
      dur  = word(i, 0) - t0;
      el   = t - t0;
      frac = 0;
      if (dur > 0 && el >= 0) frac = (el * 65536) / dur;
      if (frac > 65535) frac = 65535;
      for (int c = 0; c < NUM_COMP; c++) begin
        a = word(i - 1, c + 1);
        b = word(i, c + 1);
        push(1'b1, c, 32'(a + (((b - a) * frac) >>> 16)), 1'b1, 1'b0,
             c == NUM_COMP - 1);
      end
    end
  endfunction

  function automatic void check(kf_result_t got);
    kf_result_t exp_r;
    if (expected_q.size() == 0) begin
      $error("result with no pending request: tdata value %0d", $signed(got.val));
      errors++;
      return;
    end
    exp_r = expected_q.pop_front();
    if (got.rkind !== exp_r.rkind) begin
      $error("result_kind: expected %0d, got %0d", exp_r.rkind, got.rkind); errors++;
    end
    if (got.comp !== exp_r.comp) begin
      $error("component: expected %0d, got %0d", exp_r.comp, got.comp); errors++;
    end
    if (got.val !== exp_r.val) begin
      $error("out_value: expected %0d, got %0d", $signed(exp_r.val), $signed(got.val));
      errors++;
    end
    if (got.found !== exp_r.found) begin
      $error("found: expected %0d, got %0d", exp_r.found, got.found); errors++;
    end
    if (got.acc !== exp_r.acc) begin
      $error("accepted: expected %0d, got %0d", exp_r.acc, got.acc); errors++;
    end
    if (got.last !== exp_r.last) begin
      $error("last: expected %0d, got %0d", exp_r.last, got.last); errors++;
    end
  endfunction

  function automatic int pending();
    return expected_q.size();
  endfunction
endclass

module testbench;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  kf_scoreboard sb = new();
  int req_count = 0;    // requests accepted so far
  int idle_pct  = 0;    // chance per cycle that the sender holds off
  int stall_pct = 0;    // chance per cycle that the receiver stalls
  int last_time = 0;    // time of the most recently generated key

  keyframe_linear_interpolator dut (.*);

  always #6 clk = ~clk;

  // Watch both channels at the rising edge; everything is driven on the falling edge.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      sb.note(in_tuser, in_tdata[3:0], in_tdata[35:4]);
      req_count <= req_count + 1;
    end
    if (rst_n && out_tvalid === 1'b1 && out_tready)
      sb.check({out_tuser, out_tdata[3:0], out_tdata[35:4], out_tdata[36],
                out_tdata[37], out_tlast});
  end

  // Stall the result channel at random, per phase.
  always @(negedge clk)
    out_tready = ($urandom_range(99) >= stall_pct);

  // Hold off at random, then present one request and wait until it is taken.
  task automatic send(logic kind, logic [3:0] lane, logic [31:0] value);
    int target;
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid = 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_tuser  = kind;
    in_tdata  = {4'b0, value, lane};
    in_tvalid = 1'b1;
    target    = req_count + 1;
    while (req_count != target) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(3))
      0:       return $urandom_range(0, 1 << 18) - (1 << 17);
      1:       return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  // Load a whole key: lanes 0..12 from a random starting lane, then append with lane 13.
  task automatic load_key(logic [31:0] t);
    int first;
    first = $urandom_range(NUM_COMP - 1);
    for (int k = 0; k < NUM_COMP; k++) begin
      int ln;
      ln = (first + k) % NUM_COMP;
      send(KIND_LOAD, ln[3:0], ln == 0 ? t : rand_word());
    end
    send(KIND_LOAD, LANE_APPEND, rand_word());
    last_time = t;
  endtask

  function automatic logic [31:0] next_key_time();
    case ($urandom_range(9))
      0:       return last_time;
      1:       return $urandom();
      default: return last_time + $urandom_range(1, 1 << 18);
    endcase
  endfunction

  // Query near a stored key most of the time, anywhere otherwise.
  task automatic query_random();
    logic [31:0] t;
    int k;
    if (sb.key_count == 0 || $urandom_range(4) == 0) begin
      t = $urandom();
    end else begin
      k = $urandom_range(sb.key_count - 1);
      t = sb.key_words[k * KEY_WORDS];
      if ($urandom_range(3) != 0) t = t + $urandom_range(0, 1 << 19) - (1 << 17);
    end
    send(KIND_QUERY, 4'($urandom_range(15)), t);
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty table, ignored lanes, single key, then a two-key span at the extremes.
    send(KIND_QUERY, 4'd0, 32'd0);
    send(KIND_LOAD, 4'd14, 32'hffff_ffff);
    send(KIND_LOAD, 4'd15, 32'h0);
    load_key(32'h0064_0000);
    send(KIND_QUERY, 4'd0, 32'h8000_0000);      // before the only key: clamp
    send(KIND_QUERY, 4'd0, 32'h0064_0000);      // at the only key: not found
    load_key(32'h00c8_0000);
    send(KIND_QUERY, 4'd0, 32'h0096_0000);      // midway
    send(KIND_QUERY, 4'd0, 32'h0064_0000);      // exactly on the start key
    send(KIND_QUERY, 4'd0, 32'h00c7_ffff);      // just short of the end key
    send(KIND_QUERY, 4'd0, 32'h00c8_0000);      // on the last key: not found
    send(KIND_QUERY, 4'd0, 32'h7fff_ffff);
    send(KIND_QUERY, 4'd0, 32'h0000_0000);      // before the first key: clamp

    // Random phases: no idling, sender idle, receiver stall, light idling on both.
    for (int ph = 0; ph < 4; ph++) begin
      int base;
      idle_pct  = (ph == 1) ? 71 : (ph == 3) ? 7 : 0;
      stall_pct = (ph == 2) ? 71 : (ph == 3) ? 7 : 0;
      base = req_count;
      while (req_count - base < 14) begin
        case ($urandom_range(9))
          0, 1, 2, 3: query_random();
          4, 5, 6:    load_key(next_key_time());
          7:          send(KIND_LOAD, 4'($urandom_range(0, NUM_COMP - 1)), rand_word());
          8:          send(KIND_LOAD, 4'($urandom_range(14, 15)), $urandom());
          default: begin
            // Append only once every lane of the key being built is set.
            if (&sb.slot_mask[12:0]) send(KIND_LOAD, LANE_APPEND, rand_word());
            else query_random();
          end
        endcase
      end
      // Pause the sender until every pending result is out.
      wait_drained();
    end

    // Query the loaded table under a moderate receiver stall.
    idle_pct  = 0;
    stall_pct = 30;
    repeat (8) query_random();
    send(KIND_QUERY, 4'd0, last_time - 1);

    wait_drained();
    repeat (300) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
